[src/tpte_pkg.sv]
// Shared types, constants and the tile transform function for the tile pattern
// transform and emit core. No dependencies; all src files but tpte_ram use it.
`timescale 1ns / 1ps

package tpte_pkg;

    // Number of tileset planes held in the store.
    localparam int MAX_PLANES = 4;
    localparam int PLANE_W    = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int PCNT_W     = $clog2(MAX_PLANES + 1);
    localparam int TILES      = 256;
    localparam int ROWS       = 8;
    localparam int ROW_DEPTH  = MAX_PLANES * TILES;
    localparam int ADDR_W     = $clog2(ROW_DEPTH);

    // Command queue and output buffer depths.
    localparam int QDEPTH     = 2;
    localparam int OBUF_DEPTH = 2;

    // Action codes of an input word.
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_SINGLE = 2'd1;
    localparam logic [1:0] ACT_GROUP  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_PLANES = 1'b0;
    localparam logic CFG_FLIP   = 1'b1;

    // Attribute bit positions.
    localparam int ATTR_H = 0;
    localparam int ATTR_V = 1;
    localparam int ATTR_T = 2;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] plane;
        logic [2:0] row;
        logic [7:0] load_data;
        logic [7:0] tile0;
        logic [2:0] attr0;
        logic [7:0] tile1;
        logic [2:0] attr1;
        logic [7:0] tile2;
        logic [2:0] attr2;
        logic [7:0] tile3;
        logic [2:0] attr3;
    } t_in_word;

    typedef struct packed {
        logic [63:0] pattern;
        logic [1:0]  plane_out;
        logic [1:0]  entry_out;
        logic        last;
    } t_out_word;

    // Classified command passed from the front end to the back end.
    typedef struct packed {
        logic                  is_load;
        logic                  group;
        logic [PLANE_W-1:0]    plane;
        logic [2:0]            row;
        logic [7:0]            data;
        logic [3:0][7:0]       tiles;
        logic [3:0][2:0]       attrs;
        logic [1:0]            order;
        logic [PCNT_W-1:0]     nplanes;
    } t_cmd;

    // Transpose, then vertical flip, then horizontal flip of one 8x8 tile.
    // Row r sits in bits 8r+7..8r, bit 7 of a row is the leftmost pixel.
    function automatic logic [63:0] tpte_transform(input logic [63:0] rows,
                                                   input logic [2:0]  attr);
        logic [7:0]  a [ROWS];
        logic [7:0]  b [ROWS];
        logic [63:0] res;
        for (int r = 0; r < ROWS; r++) begin
            a[r] = rows[8*r +: 8];
        end
        if (attr[ATTR_T]) begin
            for (int j = 0; j < ROWS; j++) begin
                for (int i = 0; i < ROWS; i++) begin
                    b[j][7-i] = a[i][7-j];
                end
            end
            a = b;
        end
        if (attr[ATTR_V]) begin
            for (int r = 0; r < ROWS; r++) begin
                b[r] = a[ROWS-1-r];
            end
            a = b;
        end
        if (attr[ATTR_H]) begin
            for (int r = 0; r < ROWS; r++) begin
                for (int c = 0; c < 8; c++) begin
                    b[r][c] = a[r][7-c];
                end
            end
            a = b;
        end
        for (int r = 0; r < ROWS; r++) begin
            res[8*r +: 8] = a[r];
        end
        return res;
    endfunction

endpackage

[src/tpte_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tpte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/tpte_front.sv]
// Front end: configuration registers and classification of input words into
// commands. Depends on tpte_pkg.
`timescale 1ns / 1ps

module tpte_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [2:0]        i_cfg_data,
    input  logic              i_in_valid,
    input  tpte_pkg::t_in_word i_in_data,
    input  logic              i_q_full,
    output logic              o_in_ready,
    output logic              o_push,
    output tpte_pkg::t_cmd    o_cmd
);

    logic [2:0] r_planes;
    logic [1:0] r_flip;
    logic       accept;
    logic       keep;
    logic [tpte_pkg::PCNT_W-1:0] np;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planes <= 3'd1;
            r_flip   <= 2'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tpte_pkg::CFG_PLANES: r_planes <= i_cfg_data;
                tpte_pkg::CFG_FLIP:   r_flip   <= i_cfg_data[1:0];
                default:              r_planes <= r_planes;
            endcase
        end
    end

    // Plane count saturated to the range the store holds.
    always_comb begin
        if (r_planes == 3'd0) begin
            np = tpte_pkg::PCNT_W'(1);
        end else if (int'(r_planes) > tpte_pkg::MAX_PLANES) begin
            np = tpte_pkg::PCNT_W'(tpte_pkg::MAX_PLANES);
        end else begin
            np = tpte_pkg::PCNT_W'(r_planes);
        end
    end

    // Unused action codes and loads to missing planes are dropped here.
    always_comb begin
        unique case (i_in_data.action)
            tpte_pkg::ACT_LOAD:   keep = int'(i_in_data.plane) < tpte_pkg::MAX_PLANES;
            tpte_pkg::ACT_SINGLE: keep = 1'b1;
            tpte_pkg::ACT_GROUP:  keep = 1'b1;
            default:              keep = 1'b0;
        endcase
    end

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept && keep;

    always_comb begin
        o_cmd.is_load  = (i_in_data.action == tpte_pkg::ACT_LOAD);
        o_cmd.group    = (i_in_data.action == tpte_pkg::ACT_GROUP);
        o_cmd.plane    = tpte_pkg::PLANE_W'(i_in_data.plane);
        o_cmd.row      = i_in_data.row;
        o_cmd.data     = i_in_data.load_data;
        o_cmd.tiles[0] = i_in_data.tile0;
        o_cmd.tiles[1] = i_in_data.tile1;
        o_cmd.tiles[2] = i_in_data.tile2;
        o_cmd.tiles[3] = i_in_data.tile3;
        o_cmd.attrs[0] = i_in_data.attr0 ^ {1'b0, r_flip};
        o_cmd.attrs[1] = i_in_data.attr1 ^ {1'b0, r_flip};
        o_cmd.attrs[2] = i_in_data.attr2 ^ {1'b0, r_flip};
        o_cmd.attrs[3] = i_in_data.attr3 ^ {1'b0, r_flip};
        // Extra hflip swaps entry pairs (xor 2), extra vflip swaps neighbors (xor 1).
        o_cmd.order    = {r_flip[0], r_flip[1]};
        o_cmd.nplanes  = np;
    end

endmodule

[src/tpte_queue.sv]
// Short command queue between the front and back ends.
// Depends on tpte_pkg.
`timescale 1ns / 1ps

module tpte_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tpte_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output tpte_pkg::t_cmd o_data
);

    localparam int PW = (tpte_pkg::QDEPTH > 1) ? $clog2(tpte_pkg::QDEPTH) : 1;
    localparam int CW = $clog2(tpte_pkg::QDEPTH + 1);

    tpte_pkg::t_cmd r_mem [tpte_pkg::QDEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(tpte_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(tpte_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_full  = (r_cnt == CW'(tpte_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

endmodule

[src/tpte_back.sv]
// Back end: executes loads into the row RAMs and sequences renders, one tile
// read per cycle while the buffer has room, through the transform into
// a small output buffer. Depends on tpte_pkg and tpte_ram.
`timescale 1ns / 1ps

module tpte_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  tpte_pkg::t_cmd       i_cmd,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tpte_pkg::t_out_word  o_out_data
);

    localparam int OPW = (tpte_pkg::OBUF_DEPTH > 1) ? $clog2(tpte_pkg::OBUF_DEPTH) : 1;
    localparam int OCW = $clog2(tpte_pkg::OBUF_DEPTH + 2);

    typedef struct packed {
        logic [tpte_pkg::PLANE_W-1:0] plane;
        logic [1:0]                   entry;
        logic [2:0]                   attr;
        logic                         last;
    } t_meta;

    logic [tpte_pkg::PLANE_W-1:0] r_pl;
    logic [1:0]                   r_sl;
    logic                         r_inf;
    t_meta                        r_meta;

    tpte_pkg::t_out_word r_obuf [tpte_pkg::OBUF_DEPTH];
    logic [OPW-1:0]      r_owp;
    logic [OPW-1:0]      r_orp;
    logic [OCW-1:0]      r_occ;

    logic                          out_pop;
    logic [OCW-1:0]                pending;
    logic                          can_issue;
    logic                          load_do;
    logic                          issue;
    logic                          last_slot;
    logic                          last_issue;
    logic [1:0]                    entry;
    logic [tpte_pkg::ADDR_W-1:0]   waddr;
    logic [tpte_pkg::ADDR_W-1:0]   raddr;
    logic [7:0][7:0]               rd_rows;
    tpte_pkg::t_out_word           push_word;

    assign out_pop   = o_out_valid && i_out_ready;
    assign pending   = r_occ + OCW'(r_inf) - OCW'(out_pop);
    assign can_issue = (pending < OCW'(tpte_pkg::OBUF_DEPTH));

    assign load_do    = i_q_valid && i_cmd.is_load;
    assign issue      = i_q_valid && !i_cmd.is_load && can_issue;
    assign last_slot  = !i_cmd.group || (r_sl == 2'd3);
    assign last_issue = last_slot &&
                        (r_pl == tpte_pkg::PLANE_W'(i_cmd.nplanes - 1'b1));
    assign o_q_pop    = load_do || (issue && last_issue);

    assign entry = i_cmd.group ? (r_sl ^ i_cmd.order) : 2'd0;
    assign waddr = {i_cmd.plane, i_cmd.tiles[0]};
    assign raddr = {r_pl, i_cmd.tiles[entry]};

    for (genvar k = 0; k < tpte_pkg::ROWS; k++) begin : g_row
        tpte_ram #(
            .WIDTH (8),
            .DEPTH (tpte_pkg::ROW_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (load_do && (i_cmd.row == 3'(k))),
            .i_waddr (waddr),
            .i_wdata (i_cmd.data),
            .i_re    (issue),
            .i_raddr (raddr),
            .o_rdata (rd_rows[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pl  <= '0;
            r_sl  <= '0;
            r_inf <= 1'b0;
        end else begin
            r_inf <= issue;
            if (issue) begin
                if (last_slot) begin
                    r_sl <= '0;
                    r_pl <= last_issue ? '0 : r_pl + 1'b1;
                end else begin
                    r_sl <= r_sl + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_meta.plane <= r_pl;
            r_meta.entry <= entry;
            r_meta.attr  <= i_cmd.attrs[entry];
            r_meta.last  <= last_issue;
        end
    end

    always_comb begin
        push_word.pattern   = tpte_pkg::tpte_transform(rd_rows, r_meta.attr);
        push_word.plane_out = 2'(r_meta.plane);
        push_word.entry_out = r_meta.entry;
        push_word.last      = r_meta.last;
    end

    always_ff @(posedge i_clk) begin
        if (r_inf) begin
            r_obuf[r_owp] <= push_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp <= '0;
            r_orp <= '0;
            r_occ <= '0;
        end else begin
            if (r_inf) begin
                r_owp <= (r_owp == OPW'(tpte_pkg::OBUF_DEPTH - 1)) ? '0 : r_owp + 1'b1;
            end
            if (out_pop) begin
                r_orp <= (r_orp == OPW'(tpte_pkg::OBUF_DEPTH - 1)) ? '0 : r_orp + 1'b1;
            end
            r_occ <= r_occ + OCW'(r_inf) - OCW'(out_pop);
        end
    end

    assign o_out_valid = (r_occ != '0);
    assign o_out_data  = r_obuf[r_orp];

endmodule

[src/tile_pattern_transform_emit_core.sv]
// Top level of the tile pattern transform and emit core: front end, command
// queue and back end. Depends on tpte_pkg, tpte_front, tpte_queue, tpte_back.
`timescale 1ns / 1ps

// Channel   | Handshake                   | Payload
// ----------+-----------------------------+-------------------------------
// input     | i_in_valid / o_in_ready     | i_in_data  (tpte_pkg::t_in_word)
// output    | o_out_valid / i_out_ready   | o_out_data (tpte_pkg::t_out_word)
// config    | i_cfg_we, i_cfg_idx         | i_cfg_data (3 bits, no read-back)
//
// The front end takes one input word per cycle while the two-entry command
// queue has room. A render takes planes_in_use * entries tile reads (1 to 16),
// one per cycle while the output buffer has room, from eight row RAMs that
// share one address; a pattern passes the RAM read registers and output buffer.
// Reset is synchronous and clears configuration, queue and output buffer, not
// the tile store. A stalled output holds at most two patterns before reads pause.

module tile_pattern_transform_emit_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [2:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tpte_pkg::t_in_word   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tpte_pkg::t_out_word  o_out_data
);

    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_vld;
    tpte_pkg::t_cmd f_cmd;
    tpte_pkg::t_cmd q_cmd;

    // The front end classifies each word and holds the configuration.
    tpte_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_in_ready (o_in_ready),
        .o_push     (q_push),
        .o_cmd      (f_cmd)
    );

    // Loads travel through the queue as well, so they stay ordered with renders.
    tpte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_vld),
        .o_data  (q_cmd)
    );

    tpte_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_vld),
        .i_cmd       (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // The back end only retires a command that is present.
    a_pop_needs_cmd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_vld)
        else $error("command queue popped while empty");

    // The front end never pushes into a full queue.
    a_push_not_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command queue pushed while full");

    // No word is offered right after reset.
    a_reset_quiet : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

endmodule
